>>> design/wdc_pkg.sv
// Shared types and constants for the sliding-window distinct-value counter.
package wdc_pkg;

  localparam int KEY_W          = 32;
  localparam int COUNT_W        = 7;
  localparam int WINDOW_MAX_DEF = 64;
  localparam int GROUP_W        = 8;

  typedef struct packed {
    logic signed [KEY_W-1:0] sample_value;
    logic                    last_item;
  } wdc_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] distinct_count;
    logic               final_result;
  } wdc_out_t;

  // Control strobes broadcast from the sequencer to every cell.
  typedef struct packed {
    logic shift;
    logic clear;
    logic probe;
  } wdc_cell_ctl_t;

  // Registered compare results of one cell.
  typedef struct packed {
    logic hit_new;
    logic hit_old;
  } wdc_hit_t;

endpackage

>>> design/wdc_cell.sv
// One window cell: holds a key and its valid bit, shifts toward the older end, compares probes.
module wdc_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  wdc_pkg::wdc_cell_ctl_t       ctl,
  input  logic [wdc_pkg::KEY_W-1:0]    key_in,
  input  logic                         valid_in,
  input  logic [wdc_pkg::KEY_W-1:0]    probe_new,
  input  logic [wdc_pkg::KEY_W-1:0]    probe_old,
  input  logic [CW-1:0]                fill_level,
  input  logic [CW-1:0]                keep_len,
  output logic [wdc_pkg::KEY_W-1:0]    key,
  output logic                         valid,
  output wdc_pkg::wdc_hit_t            hit
);
  import wdc_pkg::*;

  logic in_chain;
  logic in_fill;
  logic in_older;

  // A cell takes part in the chain only below the kept length.
  assign in_chain = CW'(INDEX) < keep_len;
  assign in_fill  = CW'(INDEX) < fill_level;
  // The leaving key is searched for in all kept cells but the last one.
  assign in_older = (CW+1)'(INDEX + 1) < {1'b0, keep_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.shift && in_chain) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift && in_chain) begin
      key <= key_in;
    end
    if (ctl.probe) begin
      hit.hit_new <= valid && in_fill && (key == probe_new);
      hit.hit_old <= valid && in_older && (key == probe_old);
    end
  end

endmodule

>>> design/wdc_or_tree.sv
// Registered first level of the match reduction: one OR per group of cells.
module wdc_or_tree #(
  parameter int N     = wdc_pkg::WINDOW_MAX_DEF,
  parameter int GROUP = wdc_pkg::GROUP_W
) (
  input  logic                          clk,
  input  wdc_pkg::wdc_hit_t [N-1:0]     hits,
  output logic [(N+GROUP-1)/GROUP-1:0]  grp_new,
  output logic [(N+GROUP-1)/GROUP-1:0]  grp_old
);
  import wdc_pkg::*;

  localparam int NG = (N + GROUP - 1) / GROUP;

  logic [NG-1:0] or_new;
  logic [NG-1:0] or_old;

  always_comb begin
    or_new = '0;
    or_old = '0;
    for (int g = 0; g < NG; g++) begin
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < N) begin
          or_new[g] = or_new[g] | hits[g*GROUP+k].hit_new;
          or_old[g] = or_old[g] | hits[g*GROUP+k].hit_old;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_new <= or_new;
    grp_old <= or_old;
  end

endmodule

>>> design/window_distinct_count.sv
// Top level of the sliding-window distinct-value counter: sequencer, cell row and reduction.
// Each item passes through the compare, group-OR and final-OR steps over the cell row, and a
// new item is accepted only after the previous one has left the final step; the final step
// waits while a previous result is still held.
// Reset: window empty, running total and fill level zero, window length 1.
// A configuration write sets the length and empties the window.
module window_distinct_count #(
  parameter int WINDOW_MAX = wdc_pkg::WINDOW_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  wdc_pkg::wdc_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output wdc_pkg::wdc_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wdc_pkg::COUNT_W-1:0]    cfg_data
);
  import wdc_pkg::*;

  localparam int CW  = $clog2(WINDOW_MAX + 1);
  localparam int IW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LW  = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int NG  = (WINDOW_MAX + GROUP_W - 1) / GROUP_W;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_GRP, S_DONE} state_t;

  state_t               state;
  logic [CW-1:0]        keep_len;
  logic [CW-1:0]        fill_level;
  logic [CW-1:0]        distinct_total;
  logic [KEY_W-1:0]     x_key;
  logic                 x_last;
  logic [KEY_W-1:0]     y_key;
  logic                 y_valid;

  logic [KEY_W-1:0]     keys   [WINDOW_MAX];
  logic                 valids [WINDOW_MAX];
  wdc_hit_t [WINDOW_MAX-1:0] hits;
  logic [NG-1:0]        grp_new;
  logic [NG-1:0]        grp_old;
  wdc_cell_ctl_t        cell_ctl;

  logic                 in_fire;
  logic                 cfg_fire;
  logic [CW-1:0]        keep_m1;
  logic [IW-1:0]        sel;
  logic [LW-1:0]        cfg_ext;
  logic [CW-1:0]        cfg_keep;
  logic                 any_new;
  logic                 any_old;
  logic                 full;
  logic                 gone;
  logic                 advance;
  logic [CW-1:0]        total_inc;
  logic [CW-1:0]        total_dec;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign keep_m1 = keep_len - 1'b1;
  assign sel     = keep_m1[IW-1:0];

  // Zero is taken as length one; lengths above the cell count saturate.
  always_comb begin
    cfg_ext = LW'(cfg_data);
    if (cfg_data == '0) begin
      cfg_keep = '0;
    end else if (cfg_ext > LW'(WINDOW_MAX)) begin
      cfg_keep = CW'(WINDOW_MAX - 1);
    end else begin
      cfg_keep = CW'(cfg_ext - 1'b1);
    end
  end

  assign any_new   = |grp_new;
  assign any_old   = |grp_old;
  assign full      = (fill_level == keep_len);
  assign total_inc = distinct_total + CW'(!any_new);
  // The oldest key leaves the count only if nothing else in the window holds it.
  assign gone      = y_valid && (y_key != x_key) && !any_old;
  assign total_dec = (gone && total_inc != '0) ? total_inc - 1'b1 : total_inc;
  assign advance   = (state == S_DONE) && (!full || !out_valid || out_ready);

  assign cell_ctl.shift = advance && (keep_len != '0);
  assign cell_ctl.clear = (advance && x_last) || cfg_fire;
  assign cell_ctl.probe = (state == S_CMP);

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [KEY_W-1:0] prev_key;
    logic             prev_valid;
    if (i == 0) begin : g_head
      assign prev_key   = x_key;
      assign prev_valid = 1'b1;
    end else begin : g_link
      assign prev_key   = keys[i-1];
      assign prev_valid = valids[i-1];
    end
    wdc_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (cell_ctl),
      .key_in     (prev_key),
      .valid_in   (prev_valid),
      .probe_new  (x_key),
      .probe_old  (y_key),
      .fill_level (fill_level),
      .keep_len   (keep_len),
      .key        (keys[i]),
      .valid      (valids[i]),
      .hit        (hits[i])
    );
  end

  wdc_or_tree #(
    .N     (WINDOW_MAX),
    .GROUP (GROUP_W)
  ) u_or_tree (
    .clk     (clk),
    .hits    (hits),
    .grp_new (grp_new),
    .grp_old (grp_old)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      keep_len       <= '0;
      fill_level     <= '0;
      distinct_total <= '0;
      out_valid      <= 1'b0;
    end else begin
      // A result taken in the same cycle as a new one is loaded stays valid.
      if (out_valid && out_ready && !(advance && full)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cfg_fire) begin
            keep_len       <= cfg_keep;
            fill_level     <= '0;
            distinct_total <= '0;
          end else if (in_fire) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_GRP;
        end
        S_GRP: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (advance) begin
            state <= S_IDLE;
            if (full) begin
              out_valid               <= 1'b1;
              out_data.distinct_count <= COUNT_W'(total_inc);
              out_data.final_result   <= x_last;
            end
            if (x_last || keep_len == '0) begin
              fill_level     <= '0;
              distinct_total <= '0;
            end else if (full) begin
              distinct_total <= total_dec;
            end else begin
              distinct_total <= total_inc;
              fill_level     <= fill_level + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_key   <= in_data.sample_value;
      x_last  <= in_data.last_item;
      y_key   <= keys[sel];
      y_valid <= valids[sel] && (keep_len != '0);
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill_level <= keep_len)
    else $error("fill level exceeds kept window length");

  assert property (@(posedge clk) disable iff (rst) distinct_total <= fill_level)
    else $error("distinct total exceeds number of filled cells");

  assert property (@(posedge clk) disable iff (rst)
    cfg_fire |=> (fill_level == '0) && (distinct_total == '0))
    else $error("configuration write did not empty the window");

  assert property (@(posedge clk) disable iff (rst) in_fire |=> !in_ready && !cfg_ready)
    else $error("new item or write taken while an item is in progress");

endmodule
